>>> rtl/ist_pkg.sv
`timescale 1ns / 1ps
package ist_pkg;

  localparam int unsigned MaxIntervals = 64;
  localparam int unsigned CoordBits    = 32;
  localparam int unsigned FieldW       = 32;
  localparam int unsigned UsedW        = 7;

  typedef enum logic [1:0] {
    KIND_ADD    = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_QUERY  = 2'd2,
    KIND_RSVD   = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_INVALID = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    OP_ADD,
    OP_REMOVE,
    OP_QUERY,
    OP_INVALID
  } op_e;

  typedef struct packed {
    logic valid;
    op_e  op;
  } cmd_ctl_t;

endpackage

>>> rtl/ist_if.sv
`timescale 1ns / 1ps
interface ist_req_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  kind;
  logic [ist_pkg::FieldW-1:0]  range_left;
  logic [ist_pkg::FieldW-1:0]  range_right;
  modport source(output valid, kind, range_left, range_right, input ready);
  modport sink(input valid, kind, range_left, range_right, output ready);
endinterface

interface ist_rsp_if;
  logic                       valid;
  logic                       ready;
  logic                       covered;
  logic [1:0]                 status;
  logic [ist_pkg::UsedW-1:0]  entries_used;
  modport source(output valid, covered, status, entries_used, input ready);
  modport sink(input valid, covered, status, entries_used, output ready);
endinterface

>>> rtl/ist_front.sv
`timescale 1ns / 1ps
module ist_front #(
  parameter int unsigned CoordBits = ist_pkg::CoordBits
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  ist_req_if.sink               req_i,
  output ist_pkg::cmd_ctl_t     cmd_o,
  input  logic                  cmd_ready_i,
  output logic [CoordBits-1:0]  cmd_lo_o,
  output logic [CoordBits-1:0]  cmd_hi_o
);
  import ist_pkg::*;

  localparam int unsigned QDepth = 2;
  localparam int unsigned FillW  = $clog2(QDepth + 1);

  logic [CoordBits-1:0] lo, hi;
  op_e                  op;
  op_e                  op_q [QDepth];
  logic [CoordBits-1:0] lo_q [QDepth];
  logic [CoordBits-1:0] hi_q [QDepth];
  logic                 wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [FillW-1:0]     fill_q, fill_d;
  logic                 push, pop;

  assign lo = CoordBits'(req_i.range_left);
  assign hi = CoordBits'(req_i.range_right);

  always_comb begin
    if (req_i.kind == KIND_RSVD || lo >= hi) begin
      op = OP_INVALID;
    end else begin
      case (req_i.kind)
        KIND_ADD:    op = OP_ADD;
        KIND_REMOVE: op = OP_REMOVE;
        KIND_QUERY:  op = OP_QUERY;
        default:     op = OP_INVALID;
      endcase
    end
  end

  assign req_i.ready = (fill_q != FillW'(QDepth));
  assign push        = req_i.valid && req_i.ready;
  assign pop         = cmd_o.valid && cmd_ready_i;

  assign cmd_o.valid = (fill_q != '0);
  assign cmd_o.op    = op_q[rd_ptr_q];
  assign cmd_lo_o    = lo_q[rd_ptr_q];
  assign cmd_hi_o    = hi_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      op_q[wr_ptr_q] <= op;
      lo_q[wr_ptr_q] <= lo;
      hi_q[wr_ptr_q] <= hi;
    end
  end

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    fill_d   = fill_q;
    if (push && !pop) fill_d = fill_q + FillW'(1);
    if (pop && !push) fill_d = fill_q - FillW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

endmodule

>>> rtl/ist_back.sv
`timescale 1ns / 1ps
module ist_back #(
  parameter int unsigned MaxIntervals = ist_pkg::MaxIntervals,
  parameter int unsigned CoordBits    = ist_pkg::CoordBits
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  ist_pkg::cmd_ctl_t     cmd_i,
  output logic                  cmd_ready_o,
  input  logic [CoordBits-1:0]  cmd_lo_i,
  input  logic [CoordBits-1:0]  cmd_hi_i,
  ist_rsp_if.source             rsp_o
);
  import ist_pkg::*;

  localparam int unsigned IdxW  = $clog2(MaxIntervals);
  localparam int unsigned CntW  = $clog2(MaxIntervals + 1);
  localparam int unsigned NW    = $clog2(MaxIntervals + 2);
  localparam int unsigned Depth = 2 ** (IdxW + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_PROC,
    S_WR2,
    S_FINAL,
    S_DONE
  } state_e;

  // two banks: rebuild into the spare bank, swap on commit
  logic [CoordBits-1:0] start_mem [Depth];
  logic [CoordBits-1:0] end_mem   [Depth];

  state_e               state_q, state_d;
  op_e                  op_q, op_d;
  logic [CoordBits-1:0] lo_q, lo_d, hi_q, hi_d, ms_q, ms_d, me_q, me_d;
  logic [CoordBits-1:0] pend_s_q, pend_s_d, pend_e_q, pend_e_d;
  logic [CoordBits-1:0] s_rd_q, e_rd_q;
  logic [CntW-1:0]      i_q, i_d, count_q, count_d;
  logic [NW-1:0]        n_q, n_d;
  logic                 placed_q, placed_d, covered_q, covered_d, bank_q, bank_d;
  logic                 out_valid_q, out_valid_d, out_cov_q, out_cov_d;
  status_e              out_status_q, out_status_d;
  logic [UsedW-1:0]     out_used_q, out_used_d;
  logic                 wr_req, we, load;
  logic [CoordBits-1:0] wr_s, wr_e;
  logic [IdxW:0]        raddr, waddr;

  assign cmd_ready_o = (state_q == S_IDLE);
  assign raddr       = {bank_q, i_q[IdxW-1:0]};
  assign waddr       = {~bank_q, n_q[IdxW-1:0]};

  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    lo_d         = lo_q;
    hi_d         = hi_q;
    ms_d         = ms_q;
    me_d         = me_q;
    pend_s_d     = pend_s_q;
    pend_e_d     = pend_e_q;
    i_d          = i_q;
    n_d          = n_q;
    placed_d     = placed_q;
    covered_d    = covered_q;
    count_d      = count_q;
    bank_d       = bank_q;
    out_valid_d  = out_valid_q && !rsp_o.ready;
    out_cov_d    = out_cov_q;
    out_status_d = out_status_q;
    out_used_d   = out_used_q;
    wr_req       = 1'b0;
    wr_s         = s_rd_q;
    wr_e         = e_rd_q;
    load         = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (cmd_i.valid) begin
          op_d      = cmd_i.op;
          lo_d      = cmd_lo_i;
          hi_d      = cmd_hi_i;
          ms_d      = cmd_lo_i;
          me_d      = cmd_hi_i;
          i_d       = '0;
          n_d       = '0;
          placed_d  = 1'b0;
          covered_d = 1'b0;
          state_d   = (cmd_i.op == OP_INVALID) ? S_DONE : S_RD;
        end
      end
      S_RD: begin
        state_d = (i_q == count_q) ? S_FINAL : S_PROC;
      end
      S_PROC: begin
        i_d     = i_q + CntW'(1);
        state_d = S_RD;
        case (op_q)
          OP_QUERY: begin
            if (s_rd_q <= lo_q && hi_q <= e_rd_q) covered_d = 1'b1;
          end
          OP_ADD: begin
            if (e_rd_q < lo_q) begin
              wr_req = 1'b1;
            end else if (s_rd_q > hi_q) begin
              wr_req = 1'b1;
              if (!placed_q) begin
                wr_s     = ms_q;
                wr_e     = me_q;
                placed_d = 1'b1;
                pend_s_d = s_rd_q;
                pend_e_d = e_rd_q;
                state_d  = S_WR2;
              end
            end else begin
              if (s_rd_q < ms_q) ms_d = s_rd_q;
              if (e_rd_q > me_q) me_d = e_rd_q;
            end
          end
          OP_REMOVE: begin
            if (e_rd_q <= lo_q || s_rd_q >= hi_q) begin
              wr_req = 1'b1;
            end else if (s_rd_q < lo_q) begin
              wr_req = 1'b1;
              wr_e   = lo_q;
              if (e_rd_q > hi_q) begin
                pend_s_d = hi_q;
                pend_e_d = e_rd_q;
                state_d  = S_WR2;
              end
            end else if (e_rd_q > hi_q) begin
              wr_req = 1'b1;
              wr_s   = hi_q;
            end
          end
          default: ;
        endcase
      end
      S_WR2: begin
        wr_req  = 1'b1;
        wr_s    = pend_s_q;
        wr_e    = pend_e_q;
        state_d = S_RD;
      end
      S_FINAL: begin
        if (op_q == OP_ADD && !placed_q) begin
          wr_req = 1'b1;
          wr_s   = ms_q;
          wr_e   = me_q;
        end
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || rsp_o.ready) begin
          load      = 1'b1;
          out_cov_d = 1'b0;
          case (op_q)
            OP_INVALID: out_status_d = ST_INVALID;
            OP_QUERY: begin
              out_status_d = ST_OK;
              out_cov_d    = covered_q;
            end
            default: begin
              if (n_q > NW'(MaxIntervals)) begin
                out_status_d = ST_FULL;
              end else begin
                out_status_d = ST_OK;
                count_d      = CntW'(n_q);
                bank_d       = ~bank_q;
              end
            end
          endcase
          out_used_d  = UsedW'(count_d);
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    we = wr_req && (n_q < NW'(MaxIntervals));
    if (wr_req && n_q <= NW'(MaxIntervals)) n_d = n_q + NW'(1);
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      start_mem[waddr] <= wr_s;
      end_mem[waddr]   <= wr_e;
    end
    s_rd_q <= start_mem[raddr];
    e_rd_q <= end_mem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      count_q      <= '0;
      bank_q       <= 1'b0;
      out_valid_q  <= 1'b0;
      op_q         <= OP_INVALID;
      i_q          <= '0;
      n_q          <= '0;
      placed_q     <= 1'b0;
      covered_q    <= 1'b0;
      out_status_q <= ST_OK;
    end else begin
      state_q      <= state_d;
      count_q      <= count_d;
      bank_q       <= bank_d;
      out_valid_q  <= out_valid_d;
      op_q         <= op_d;
      i_q          <= i_d;
      n_q          <= n_d;
      placed_q     <= placed_d;
      covered_q    <= covered_d;
      out_status_q <= out_status_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q       <= lo_d;
    hi_q       <= hi_d;
    ms_q       <= ms_d;
    me_q       <= me_d;
    pend_s_q   <= pend_s_d;
    pend_e_q   <= pend_e_d;
    out_cov_q  <= out_cov_d;
    out_used_q <= out_used_d;
  end

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.covered      = out_cov_q;
  assign rsp_o.status       = out_status_q;
  assign rsp_o.entries_used = out_used_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MaxIntervals))
    else $error("entry count above table size");

  a_full_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && out_status_d == ST_FULL) |=> (count_q == $past(count_q) && bank_q == $past(bank_q)))
    else $error("dropped request changed the table");

  a_cov_query: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && out_cov_d) |-> (op_q == OP_QUERY))
    else $error("covered flagged on a non-query");

  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PROC) |-> (i_q < count_q))
    else $error("scan past stored entries");

endmodule

>>> rtl/interval_set_tracker.sv
`timescale 1ns / 1ps
// Interval set tracker: sorted table of disjoint half-open ranges.
// req_i carries kind (add, remove, query), range_left and range_right; a
// transaction is taken when valid and ready are both high. rsp_o returns
// one transaction per request, in order: covered, status, entries_used.
// The front classifies each request and parks it in a two-deep queue; the
// back walks the stored entries one at a time through a registered memory
// port and writes the rebuilt table into the spare bank, which becomes
// live when the request commits. A split, or a placement before a later
// entry, adds the S_WR2 write state; invalid requests skip the scan. The
// back takes one request at a time and accepts no new one until the last
// one has left S_DONE.
// Reset empties the table at once (count cleared, no clearing pass).
// When the receiver stalls the result is held in the output register; the
// back finishes the next request and then waits, while the front keeps
// taking requests until its queue is full.
module interval_set_tracker #(
  parameter int unsigned MaxIntervals = ist_pkg::MaxIntervals,
  parameter int unsigned CoordBits    = ist_pkg::CoordBits
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  ist_req_if.sink   req_i,
  ist_rsp_if.source rsp_o
);
  import ist_pkg::*;

  cmd_ctl_t             cmd;
  logic                 cmd_ready;
  logic [CoordBits-1:0] cmd_lo, cmd_hi;

  ist_front #(
    .CoordBits(CoordBits)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_i),
    .cmd_o      (cmd),
    .cmd_ready_i(cmd_ready),
    .cmd_lo_o   (cmd_lo),
    .cmd_hi_o   (cmd_hi)
  );

  ist_back #(
    .MaxIntervals(MaxIntervals),
    .CoordBits   (CoordBits)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .cmd_ready_o(cmd_ready),
    .cmd_lo_i   (cmd_lo),
    .cmd_hi_i   (cmd_hi),
    .rsp_o      (rsp_o)
  );

endmodule
